// ===== src/assert_macros.svh =====
// Assertion macros shared by the console writer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TCW_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tcw assertion failed");
`define TCW_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tcw assertion failed");
`else
`define TCW_ASSERT(lbl, clk, rst_n, prop)
`define TCW_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// ===== src/tcw_pkg.sv =====
package tcw_pkg;

  localparam int COLS_DEF        = 32;
  localparam int TEXT_ROWS_DEF   = 16;
  localparam int NUM_SCREENS_DEF = 4;

  localparam int REQ_W    = 3;
  localparam int SCR_W    = 2;
  localparam int CHAR_W   = 8;
  localparam int COL_W    = 5;
  localparam int ROW_W    = 4;
  localparam int COLOUR_W = 8;
  localparam int BOTTOM_W = 4;

  localparam int APB_DATA_W  = 32;
  localparam int PADDR_W     = 3;
  localparam int REG_IDX_LSB = 2;
  localparam int REG_IDX_W   = 1;

  localparam int NARROW_W  = 8;
  localparam int MOD_STEPS = 3;

  localparam logic [REQ_W-1:0] REQ_PUT_CHAR     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_POKE         = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SET_CURSOR   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR_SCREEN = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR_LINE   = 3'd4;
  localparam logic [REQ_W-1:0] REQ_READ_CELL    = 3'd5;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0a;
  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;

  localparam logic [COLOUR_W-1:0] FILL_RESET   = 8'd0;
  localparam logic [BOTTOM_W-1:0] BOTTOM_RESET = 4'd4;

  localparam logic [REG_IDX_W-1:0] REG_FILL   = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_BOTTOM = 1'b1;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [SCR_W-1:0]  screen_sel;
    logic [CHAR_W-1:0] char_code;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } in_word_t;

  typedef struct packed {
    logic [CHAR_W-1:0]   cell_char;
    logic [COLOUR_W-1:0] cell_colour;
    logic [COL_W-1:0]    cursor_col;
    logic [ROW_W-1:0]    cursor_row;
  } out_word_t;

  typedef struct packed {
    logic [COLOUR_W-1:0] fill_colour;
    logic [BOTTOM_W-1:0] cursor_bottom_row;
  } cfg_t;

  typedef enum logic [2:0] {
    WR_NONE, WR_RESET, WR_CURSOR, WR_POKE, WR_BLANK
  } wr_op_t;

  typedef enum logic [1:0] {
    RD_NONE, RD_CELL, RD_SCROLL
  } rd_op_t;

  typedef enum logic [2:0] {
    CUR_NONE, CUR_BS, CUR_ADV, CUR_NL, CUR_SET, CUR_HOME
  } cur_op_t;

  typedef enum logic [2:0] {
    SWEEP_NONE, SWEEP_SCREEN, SWEEP_LINE, SWEEP_SCROLL, SWEEP_LAST
  } sweep_op_t;

  typedef struct packed {
    logic      latch;
    wr_op_t    wr;
    rd_op_t    rd;
    cur_op_t   cur;
    sweep_op_t sweep;
    logic      step;
    logic      out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic             is_bs;
    logic             is_nl;
    logic             col_wrap;
    logic             sweep_last;
    logic             clr_last;
    logic             out_busy;
  } dp_stat_t;

  // Reduces a small value that is at most a few times the bound.
  function automatic logic [NARROW_W-1:0] wrap_down(input logic [NARROW_W-1:0] v,
                                                    input logic [NARROW_W-1:0] m);
    logic [NARROW_W-1:0] acc;
    acc = v;
    for (int i = 0; i < MOD_STEPS; i++) begin
      if (acc >= m) begin
        acc = acc - m;
      end
    end
    return acc;
  endfunction

endpackage

// ===== src/tcw_regs.sv =====
module tcw_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tcw_pkg::PADDR_W-1:0]         paddr,
  input  logic [tcw_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [tcw_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready,
  output tcw_pkg::cfg_t                       cfg
);

  localparam int DW = tcw_pkg::APB_DATA_W;

  logic [tcw_pkg::COLOUR_W-1:0]  fill_colour_r;
  logic [tcw_pkg::BOTTOM_W-1:0]  bottom_r;
  logic [tcw_pkg::REG_IDX_W-1:0] idx;
  logic                          wr_en;

  assign idx    = paddr[tcw_pkg::REG_IDX_LSB +: tcw_pkg::REG_IDX_W];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_colour_r <= tcw_pkg::FILL_RESET;
      bottom_r      <= tcw_pkg::BOTTOM_RESET;
    end else if (wr_en) begin
      case (idx)
        tcw_pkg::REG_FILL: begin
          fill_colour_r <= pwdata[tcw_pkg::COLOUR_W-1:0];
        end
        tcw_pkg::REG_BOTTOM: begin
          bottom_r <= pwdata[tcw_pkg::BOTTOM_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      tcw_pkg::REG_FILL:   prdata = DW'(fill_colour_r);
      tcw_pkg::REG_BOTTOM: prdata = DW'(bottom_r);
      default:             prdata = '0;
    endcase
  end

  assign cfg.fill_colour       = fill_colour_r;
  assign cfg.cursor_bottom_row = bottom_r;

endmodule

// ===== src/tcw_ctrl.sv =====
`include "assert_macros.svh"

module tcw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output tcw_pkg::dp_cmd_t  cmd,
  input  tcw_pkg::dp_stat_t stat
);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_DECODE = 7'b0000100,
    S_SCROLL = 7'b0001000,
    S_DRAIN  = 7'b0010000,
    S_BLANK  = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd.latch    = 1'b0;
    cmd.wr       = tcw_pkg::WR_NONE;
    cmd.rd       = tcw_pkg::RD_NONE;
    cmd.cur      = tcw_pkg::CUR_NONE;
    cmd.sweep    = tcw_pkg::SWEEP_NONE;
    cmd.step     = 1'b0;
    cmd.out_load = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.wr = tcw_pkg::WR_RESET;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_DONE;
        case (stat.req_type)
          tcw_pkg::REQ_PUT_CHAR: begin
            if (stat.is_bs) begin
              cmd.cur = tcw_pkg::CUR_BS;
            end else if (stat.is_nl) begin
              cmd.cur   = tcw_pkg::CUR_NL;
              cmd.sweep = tcw_pkg::SWEEP_SCROLL;
              state_nxt = S_SCROLL;
            end else begin
              cmd.wr  = tcw_pkg::WR_CURSOR;
              cmd.cur = tcw_pkg::CUR_ADV;
              if (stat.col_wrap) begin
                cmd.sweep = tcw_pkg::SWEEP_SCROLL;
                state_nxt = S_SCROLL;
              end
            end
          end
          tcw_pkg::REQ_POKE: begin
            cmd.wr = tcw_pkg::WR_POKE;
          end
          tcw_pkg::REQ_SET_CURSOR: begin
            cmd.cur = tcw_pkg::CUR_SET;
          end
          tcw_pkg::REQ_CLEAR_SCREEN: begin
            cmd.cur   = tcw_pkg::CUR_HOME;
            cmd.sweep = tcw_pkg::SWEEP_SCREEN;
            state_nxt = S_BLANK;
          end
          tcw_pkg::REQ_CLEAR_LINE: begin
            cmd.sweep = tcw_pkg::SWEEP_LINE;
            state_nxt = S_BLANK;
          end
          tcw_pkg::REQ_READ_CELL: begin
            cmd.rd = tcw_pkg::RD_CELL;
          end
          default: begin
          end
        endcase
      end
      S_SCROLL: begin
        cmd.rd   = tcw_pkg::RD_SCROLL;
        cmd.step = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd.sweep = tcw_pkg::SWEEP_LAST;
        state_nxt = S_BLANK;
      end
      S_BLANK: begin
        cmd.wr   = tcw_pkg::WR_BLANK;
        cmd.step = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  `TCW_ASSERT_NR(a_reset_starts_clear, clk, (!rst_n) |=> (state_r == S_CLEAR))
  `TCW_ASSERT(a_accept_decodes, clk, rst_n, (in_valid && !in_stall) |=> (state_r == S_DECODE))

endmodule

// ===== src/tcw_dp.sv =====
`include "assert_macros.svh"

module tcw_dp #(
  parameter int COLS        = tcw_pkg::COLS_DEF,
  parameter int TEXT_ROWS   = tcw_pkg::TEXT_ROWS_DEF,
  parameter int NUM_SCREENS = tcw_pkg::NUM_SCREENS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tcw_pkg::in_word_t  in_data,
  input  tcw_pkg::cfg_t      cfg,
  input  tcw_pkg::dp_cmd_t   cmd,
  output tcw_pkg::dp_stat_t  stat,
  input  logic               out_stall,
  output logic               out_valid,
  output tcw_pkg::out_word_t out_data
);

  localparam int CW    = $clog2(COLS);
  localparam int RW    = $clog2(TEXT_ROWS);
  localparam int SW    = (NUM_SCREENS > 1) ? $clog2(NUM_SCREENS) : 1;
  localparam int AW    = SW + RW + CW;
  localparam int DEPTH = 1 << AW;
  localparam int NW    = tcw_pkg::NARROW_W;
  localparam int MW    = tcw_pkg::CHAR_W + tcw_pkg::COLOUR_W;
  localparam int COLW  = tcw_pkg::COL_W;
  localparam int ROWW  = tcw_pkg::ROW_W;

  localparam logic [CW-1:0] LAST_COL   = CW'(COLS - 1);
  localparam logic [RW-1:0] LAST_ROW   = RW'(TEXT_ROWS - 1);
  localparam logic [RW-1:0] SCROLL_END = RW'(TEXT_ROWS - 2);

  logic [tcw_pkg::REQ_W-1:0]  req_r;
  logic [SW-1:0]              scr_r;
  logic [tcw_pkg::CHAR_W-1:0] ch_r;
  logic [CW-1:0]              c_r;
  logic [RW-1:0]              r_r;
  logic [SW-1:0]              scr_in;
  logic [CW-1:0]              c_in;
  logic [RW-1:0]              r_in;

  assign scr_in = SW'(tcw_pkg::wrap_down(NW'(in_data.screen_sel), NW'(NUM_SCREENS)));
  assign c_in   = CW'(tcw_pkg::wrap_down(NW'(in_data.col), NW'(COLS)));
  assign r_in   = RW'(tcw_pkg::wrap_down(NW'(in_data.row), NW'(TEXT_ROWS)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r <= '0;
      scr_r <= '0;
      ch_r  <= '0;
      c_r   <= '0;
      r_r   <= '0;
    end else if (cmd.latch) begin
      req_r <= in_data.req_type;
      scr_r <= scr_in;
      ch_r  <= in_data.char_code;
      c_r   <= c_in;
      r_r   <= r_in;
    end
  end

  logic [CW-1:0] cur_col_r [NUM_SCREENS];
  logic [RW-1:0] cur_row_r [NUM_SCREENS];
  logic [CW-1:0] cc, cc_nxt;
  logic [RW-1:0] cr, cr_nxt, bot, nl_row;
  logic [NW-1:0] row_inc;
  logic          cur_we;

  assign cc = cur_col_r[scr_r];
  assign cr = cur_row_r[scr_r];

  always_comb begin
    if (NW'(cfg.cursor_bottom_row) > NW'(TEXT_ROWS - 1)) begin
      bot = LAST_ROW;
    end else begin
      bot = RW'(cfg.cursor_bottom_row);
    end
  end

  assign row_inc = NW'(cr) + NW'(1);
  assign nl_row  = (row_inc > NW'(bot)) ? bot : RW'(row_inc);

  always_comb begin
    cur_we = 1'b1;
    cc_nxt = cc;
    cr_nxt = cr;
    case (cmd.cur)
      tcw_pkg::CUR_BS: begin
        if (cc != '0) begin
          cc_nxt = cc - CW'(1);
        end
      end
      tcw_pkg::CUR_ADV: begin
        if (cc == LAST_COL) begin
          cc_nxt = '0;
          cr_nxt = nl_row;
        end else begin
          cc_nxt = cc + CW'(1);
        end
      end
      tcw_pkg::CUR_NL: begin
        cc_nxt = '0;
        cr_nxt = nl_row;
      end
      tcw_pkg::CUR_SET: begin
        cc_nxt = c_r;
        cr_nxt = r_r;
      end
      tcw_pkg::CUR_HOME: begin
        cc_nxt = '0;
        cr_nxt = '0;
      end
      default: begin
        cur_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_SCREENS; s++) begin
        cur_col_r[s] <= '0;
        cur_row_r[s] <= '0;
      end
    end else if (cur_we) begin
      cur_col_r[scr_r] <= cc_nxt;
      cur_row_r[scr_r] <= cr_nxt;
    end
  end

  logic [RW-1:0] row_cnt_r, end_row_r, row_src;
  logic [CW-1:0] col_cnt_r;

  assign row_src = row_cnt_r + RW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= '0;
      end_row_r <= '0;
      col_cnt_r <= '0;
    end else begin
      case (cmd.sweep)
        tcw_pkg::SWEEP_SCREEN: begin
          row_cnt_r <= '0;
          end_row_r <= LAST_ROW;
          col_cnt_r <= '0;
        end
        tcw_pkg::SWEEP_LINE: begin
          row_cnt_r <= r_r;
          end_row_r <= r_r;
          col_cnt_r <= '0;
        end
        tcw_pkg::SWEEP_SCROLL: begin
          row_cnt_r <= RW'(1);
          end_row_r <= SCROLL_END;
          col_cnt_r <= '0;
        end
        tcw_pkg::SWEEP_LAST: begin
          row_cnt_r <= LAST_ROW;
          end_row_r <= LAST_ROW;
          col_cnt_r <= '0;
        end
        default: begin
          if (cmd.step) begin
            if (col_cnt_r == LAST_COL) begin
              col_cnt_r <= '0;
              row_cnt_r <= row_src;
            end else begin
              col_cnt_r <= col_cnt_r + CW'(1);
            end
          end
        end
      endcase
    end
  end

  logic [AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.wr == tcw_pkg::WR_RESET) begin
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  logic [MW-1:0] mem [DEPTH];
  logic [MW-1:0] rdata_r, wdata;
  logic [AW-1:0] waddr, raddr, cp_addr_r;
  logic          we, re, cp_vld_r;

  always_comb begin
    we    = 1'b0;
    waddr = cp_addr_r;
    wdata = rdata_r;
    if (cp_vld_r) begin
      we = 1'b1;
    end else begin
      case (cmd.wr)
        tcw_pkg::WR_RESET: begin
          we    = 1'b1;
          waddr = clr_addr_r;
          wdata = {tcw_pkg::BLANK_CHAR, tcw_pkg::FILL_RESET};
        end
        tcw_pkg::WR_CURSOR: begin
          we    = 1'b1;
          waddr = {scr_r, cr, cc};
          wdata = {ch_r, cfg.fill_colour};
        end
        tcw_pkg::WR_POKE: begin
          we    = 1'b1;
          waddr = {scr_r, r_r, c_r};
          wdata = {ch_r, cfg.fill_colour};
        end
        tcw_pkg::WR_BLANK: begin
          we    = 1'b1;
          waddr = {scr_r, row_cnt_r, col_cnt_r};
          wdata = {tcw_pkg::BLANK_CHAR, cfg.fill_colour};
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    re    = 1'b0;
    raddr = {scr_r, r_r, c_r};
    case (cmd.rd)
      tcw_pkg::RD_CELL: begin
        re = 1'b1;
      end
      tcw_pkg::RD_SCROLL: begin
        re    = 1'b1;
        raddr = {scr_r, row_src, col_cnt_r};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cp_vld_r <= 1'b0;
    end else begin
      cp_vld_r <= (cmd.rd == tcw_pkg::RD_SCROLL);
    end
  end

  always_ff @(posedge clk) begin
    cp_addr_r <= {scr_r, row_cnt_r, col_cnt_r};
  end

  logic               out_valid_r;
  tcw_pkg::out_word_t out_data_r;
  logic [NW-1:0]      cc_w, cr_w;

  assign cc_w = NW'(cc);
  assign cr_w = NW'(cr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (req_r == tcw_pkg::REQ_READ_CELL) begin
        {out_data_r.cell_char, out_data_r.cell_colour} <= rdata_r;
      end else begin
        out_data_r.cell_char   <= '0;
        out_data_r.cell_colour <= '0;
      end
      out_data_r.cursor_col <= cc_w[COLW-1:0];
      out_data_r.cursor_row <= cr_w[ROWW-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign stat.req_type   = req_r;
  assign stat.is_bs      = (ch_r == tcw_pkg::CH_BACKSPACE);
  assign stat.is_nl      = (ch_r == tcw_pkg::CH_NEWLINE);
  assign stat.col_wrap   = (cc == LAST_COL);
  assign stat.sweep_last = (col_cnt_r == LAST_COL) && (row_cnt_r == end_row_r);
  assign stat.clr_last   = &clr_addr_r;
  assign stat.out_busy   = out_valid_r && out_stall;

  `TCW_ASSERT(a_copy_owns_port, clk, rst_n, cp_vld_r |-> (cmd.wr == tcw_pkg::WR_NONE))
  `TCW_ASSERT(a_cursor_range, clk, rst_n, (NW'(cc) < NW'(COLS)) && (NW'(cr) < NW'(TEXT_ROWS)))
  `TCW_ASSERT(a_out_after_load, clk, rst_n, $rose(out_valid_r) |-> $past(cmd.out_load))

endmodule

// ===== src/text_console_writer_core.sv =====
// Channel  Handshake                          Content
// in_      in_valid / in_stall                one request word, tcw_pkg::in_word_t
// out_     out_valid / out_stall              one result word per request
// cfg_     cfg_psel, cfg_penable, cfg_pready  fill_colour at 0x0, cursor_bottom_row at 0x4
//
// After reset the block sweeps the whole cell memory, one entry per cycle,
// 2**(screen, row and column address bits) entries (2048 at the defaults), with in_stall high.
// Put_char without newline or column wrap, poke, set_cursor, read_cell and backspace go from decode to done.
// A newline scroll is bound by the single write port: it copies cells, then blanks the last row.
// Clear_screen blanks every cell of the screen and clear_line every cell of the addressed row.
// A stalled result word waits in the output register while the next word is taken in.
module text_console_writer_core #(
  parameter int COLS        = tcw_pkg::COLS_DEF,
  parameter int TEXT_ROWS   = tcw_pkg::TEXT_ROWS_DEF,
  parameter int NUM_SCREENS = tcw_pkg::NUM_SCREENS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  tcw_pkg::in_word_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output tcw_pkg::out_word_t             out_data,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [tcw_pkg::PADDR_W-1:0]    cfg_paddr,
  input  logic [tcw_pkg::APB_DATA_W-1:0] cfg_pwdata,
  output logic [tcw_pkg::APB_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  tcw_pkg::cfg_t     cfg;
  tcw_pkg::dp_cmd_t  cmd;
  tcw_pkg::dp_stat_t stat;

  tcw_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  tcw_dp #(
    .COLS        (COLS),
    .TEXT_ROWS   (TEXT_ROWS),
    .NUM_SCREENS (NUM_SCREENS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg       (cfg),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== bench/text_console_writer_core_tb.sv =====
`timescale 1ns / 1ps

module text_console_writer_core_tb;
  import tcw_pkg::*;

  localparam int NCOLS = COLS_DEF;
  localparam int NROWS = TEXT_ROWS_DEF;
  localparam int SCREEN_CELLS = NCOLS * NROWS;
  localparam int ALL_CELLS = SCREEN_CELLS * NUM_SCREENS_DEF;
  localparam int QUIET_LIMIT = 20000;
  localparam int TAIL_CYCLES = 600;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 146;

  localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

  typedef struct packed {
    in_word_t  w;
    logic      typed;
    out_word_t r;
  } dir_row_t;

  localparam int DIR_N = 25;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    {REQ_READ_CELL,    2'd0, 8'h00,        5'd0,  4'd0,  1'b1, 8'h20, 8'h00, 5'd0,  4'd0},
    {REQ_READ_CELL,    2'd3, 8'h00,        5'd31, 4'd15, 1'b1, 8'h20, 8'h00, 5'd0,  4'd0},
    {REQ_PUT_CHAR,     2'd0, 8'h41,        5'd0,  4'd0,  1'b1, 8'h00, 8'h00, 5'd1,  4'd0},
    {REQ_READ_CELL,    2'd0, 8'h00,        5'd0,  4'd0,  1'b1, 8'h41, 8'h00, 5'd1,  4'd0},
    {REQ_PUT_CHAR,     2'd0, CH_BACKSPACE, 5'd0,  4'd0,  1'b1, 8'h00, 8'h00, 5'd0,  4'd0},
    {REQ_PUT_CHAR,     2'd0, CH_BACKSPACE, 5'd31, 4'd15, 1'b1, 8'h00, 8'h00, 5'd0,  4'd0},
    {REQ_PUT_CHAR,     2'd0, CH_NEWLINE,   5'd0,  4'd0,  1'b1, 8'h00, 8'h00, 5'd0,  4'd1},
    {REQ_READ_CELL,    2'd0, 8'h00,        5'd0,  4'd0,  1'b1, 8'h41, 8'h00, 5'd0,  4'd1},
    {REQ_SET_CURSOR,   2'd1, 8'h00,        5'd31, 4'd15, 1'b1, 8'h00, 8'h00, 5'd31, 4'd15},
    {REQ_PUT_CHAR,     2'd1, 8'hff,        5'd0,  4'd0,  1'b1, 8'h00, 8'h00, 5'd0,  4'd4},
    {REQ_READ_CELL,    2'd1, 8'h00,        5'd31, 4'd14, 1'b0, 25'd0},
    {REQ_POKE,         2'd2, 8'h00,        5'd31, 4'd15, 1'b1, 8'h00, 8'h00, 5'd0,  4'd0},
    {REQ_READ_CELL,    2'd2, 8'h00,        5'd31, 4'd15, 1'b1, 8'h00, 8'h00, 5'd0,  4'd0},
    {REQ_POKE,         2'd2, 8'hff,        5'd0,  4'd0,  1'b1, 8'h00, 8'h00, 5'd0,  4'd0},
    {REQ_READ_CELL,    2'd2, 8'h00,        5'd0,  4'd0,  1'b1, 8'hff, 8'h00, 5'd0,  4'd0},
    {REQ_CLEAR_LINE,   2'd2, 8'hff,        5'd31, 4'd15, 1'b1, 8'h00, 8'h00, 5'd0,  4'd0},
    {REQ_READ_CELL,    2'd2, 8'h00,        5'd31, 4'd15, 1'b1, 8'h20, 8'h00, 5'd0,  4'd0},
    {REQ_SPARE_6,      2'd0, 8'hff,        5'd31, 4'd15, 1'b1, 8'h00, 8'h00, 5'd0,  4'd1},
    {REQ_SPARE_7,      2'd3, 8'hff,        5'd31, 4'd15, 1'b1, 8'h00, 8'h00, 5'd0,  4'd0},
    {REQ_CLEAR_SCREEN, 2'd0, 8'h00,        5'd0,  4'd0,  1'b1, 8'h00, 8'h00, 5'd0,  4'd0},
    {REQ_READ_CELL,    2'd0, 8'h00,        5'd0,  4'd0,  1'b1, 8'h20, 8'h00, 5'd0,  4'd0},
    {REQ_SET_CURSOR,   2'd3, 8'h00,        5'd5,  4'd10, 1'b1, 8'h00, 8'h00, 5'd5,  4'd10},
    {REQ_PUT_CHAR,     2'd3, CH_NEWLINE,   5'd0,  4'd0,  1'b1, 8'h00, 8'h00, 5'd0,  4'd4},
    {REQ_PUT_CHAR,     2'd3, 8'h7e,        5'd0,  4'd0,  1'b0, 25'd0},
    {REQ_READ_CELL,    2'd3, 8'h00,        5'd0,  4'd4,  1'b0, 25'd0}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_word_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_word_t             out_data;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [PADDR_W-1:0]    cfg_paddr;
  logic [APB_DATA_W-1:0] cfg_pwdata;
  logic [APB_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  logic [CHAR_W-1:0]   char_mem   [ALL_CELLS];
  logic [COLOUR_W-1:0] colour_mem [ALL_CELLS];
  int                  cur_c [NUM_SCREENS_DEF];
  int                  cur_r [NUM_SCREENS_DEF];
  logic [COLOUR_W-1:0] fill_reg;
  logic [BOTTOM_W-1:0] bottom_reg;

  out_word_t pending_results [$];
  int        send_pct;
  int        stall_pct;
  int        n_requests;
  int        n_results;
  int        n_errors;
  int        quiet_cycles;

  text_console_writer_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic void blank_span(input int base, input int count);
    for (int k = 0; k < count; k++) begin
      char_mem[base + k] = BLANK_CHAR;
      colour_mem[base + k] = fill_reg;
    end
  endfunction

  function automatic void scroll_screen(input int s, input int base);
    int bottom;
    bottom = (int'(bottom_reg) > NROWS - 1) ? NROWS - 1 : int'(bottom_reg);
    cur_c[s] = 0;
    cur_r[s] = cur_r[s] + 1;
    if (cur_r[s] > bottom) begin
      cur_r[s] = bottom;
    end
    for (int k = NCOLS; k < SCREEN_CELLS - NCOLS; k++) begin
      char_mem[base + k] = char_mem[base + k + NCOLS];
      colour_mem[base + k] = colour_mem[base + k + NCOLS];
    end
    blank_span(base + (NROWS - 1) * NCOLS, NCOLS);
  endfunction

  function automatic out_word_t console_predict(input in_word_t w);
    out_word_t res;
    int s;
    int base;
    int c;
    int r;
    int a;
    s = int'(w.screen_sel) % NUM_SCREENS_DEF;
    c = int'(w.col) % NCOLS;
    r = int'(w.row) % NROWS;
    base = s * SCREEN_CELLS;
    res = '0;
    case (w.req_type)
      REQ_PUT_CHAR: begin
        if (w.char_code == CH_BACKSPACE) begin
          if (cur_c[s] > 0) begin
            cur_c[s] = cur_c[s] - 1;
          end
        end else if (w.char_code == CH_NEWLINE) begin
          scroll_screen(s, base);
        end else begin
          a = base + cur_r[s] * NCOLS + cur_c[s];
          char_mem[a] = w.char_code;
          colour_mem[a] = fill_reg;
          cur_c[s] = cur_c[s] + 1;
          if (cur_c[s] > NCOLS - 1) begin
            cur_c[s] = 0;
            scroll_screen(s, base);
          end
        end
      end
      REQ_POKE: begin
        a = base + r * NCOLS + c;
        char_mem[a] = w.char_code;
        colour_mem[a] = fill_reg;
      end
      REQ_SET_CURSOR: begin
        cur_c[s] = c;
        cur_r[s] = r;
      end
      REQ_CLEAR_SCREEN: begin
        blank_span(base, SCREEN_CELLS);
        cur_c[s] = 0;
        cur_r[s] = 0;
      end
      REQ_CLEAR_LINE: begin
        blank_span(base + r * NCOLS, NCOLS);
      end
      REQ_READ_CELL: begin
        res.cell_char = char_mem[base + r * NCOLS + c];
        res.cell_colour = colour_mem[base + r * NCOLS + c];
      end
      default: begin
      end
    endcase
    res.cursor_col = COL_W'(cur_c[s]);
    res.cursor_row = ROW_W'(cur_r[s]);
    return res;
  endfunction

  function automatic in_word_t random_request();
    in_word_t w;
    int pick;
    int k;
    pick = $urandom_range(99);
    w.screen_sel = SCR_W'($urandom_range(3));
    w.char_code = CHAR_W'($urandom_range(255));
    w.col = COL_W'($urandom_range(31));
    w.row = ROW_W'($urandom_range(15));
    if (pick < 42) begin
      w.req_type = REQ_PUT_CHAR;
      k = $urandom_range(99);
      if (k < 62) begin
        w.char_code = CHAR_W'(8'h20 + $urandom_range(94));
      end else if (k < 70) begin
        w.char_code = CH_BACKSPACE;
      end else if (k < 78) begin
        w.char_code = CH_NEWLINE;
      end
    end else if (pick < 57) begin
      w.req_type = REQ_POKE;
    end else if (pick < 67) begin
      w.req_type = REQ_SET_CURSOR;
    end else if (pick < 69) begin
      w.req_type = REQ_CLEAR_SCREEN;
    end else if (pick < 75) begin
      w.req_type = REQ_CLEAR_LINE;
    end else if (pick < 95) begin
      w.req_type = REQ_READ_CELL;
    end else begin
      w.req_type = ($urandom_range(1) == 0) ? REQ_SPARE_6 : REQ_SPARE_7;
    end
    return w;
  endfunction

  task automatic send_request(input in_word_t w, input logic typed, input out_word_t known);
    out_word_t pred;
    @(negedge clk);
    while ($urandom_range(99) < send_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = w;
    do begin
      @(posedge clk);
    end while (in_stall);
    pred = console_predict(w);
    pending_results.push_back(typed ? known : pred);
    n_requests++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
  endtask

  task automatic write_register(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    logic [31:0] mask;
    logic [31:0] rd;
    mask = (idx == REG_FILL) ? 32'h0000_00ff : 32'h0000_000f;
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = PADDR_W'(idx) << REG_IDX_LSB;
    cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do begin
      @(posedge clk);
    end while (!cfg_pready);
    @(negedge clk);
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do begin
      @(posedge clk);
    end while (!cfg_pready);
    rd = cfg_prdata;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    if (rd !== (value & mask)) begin
      $display("%0t: register %0d read back expected %h actual %h", $time, idx,
               value & mask, rd);
      n_errors++;
    end
    if (idx == REG_FILL) begin
      fill_reg = value[COLOUR_W-1:0];
    end else begin
      bottom_reg = value[BOTTOM_W-1:0];
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, out_data);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.cell_char !== want.cell_char ||
            out_data.cell_colour !== want.cell_colour ||
            out_data.cursor_col !== want.cursor_col ||
            out_data.cursor_row !== want.cursor_row) begin
          $display("%0t: result mismatch expected %h actual %h", $time, want, out_data);
          n_errors++;
        end
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_psel && cfg_penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding", $time,
               QUIET_LIMIT, pending_results.size());
      $display("text_console_writer_core_tb NOT OK");
      $finish;
    end
  end

  initial begin
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    send_pct = 0;
    stall_pct = 0;
    n_requests = 0;
    n_results = 0;
    n_errors = 0;
    quiet_cycles = 0;
    fill_reg = FILL_RESET;
    bottom_reg = BOTTOM_RESET;
    blank_span(0, ALL_CELLS);
    for (int s = 0; s < NUM_SCREENS_DEF; s++) begin
      cur_c[s] = 0;
      cur_r[s] = 0;
    end
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < DIR_N; i++) begin
      send_request(DIR_ROWS[i].w, DIR_ROWS[i].typed, DIR_ROWS[i].r);
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        0: begin
          write_register(REG_FILL, 32'h0000_00ff);
          write_register(REG_BOTTOM, 32'h0000_000f);
        end
        1: begin
          write_register(REG_FILL, 32'h0000_0000);
          write_register(REG_BOTTOM, 32'h0000_0000);
        end
        3: begin
          write_register(REG_FILL, 32'h0000_007e);
          write_register(REG_BOTTOM, 32'h0000_0001);
        end
        5: begin
          write_register(REG_FILL, 32'h0000_0001);
          write_register(REG_BOTTOM, 32'h0000_000e);
        end
        7: begin
          write_register(REG_FILL, 32'h0000_0080);
          write_register(REG_BOTTOM, 32'(BOTTOM_RESET));
        end
        default: begin
          write_register(REG_FILL, 32'($urandom_range(255)));
          write_register(REG_BOTTOM, 32'($urandom_range(15)));
        end
      endcase
      case (p % 4)
        0: begin
          send_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_pct = 72;
          stall_pct = 0;
        end
        2: begin
          send_pct = 0;
          stall_pct = 72;
        end
        default: begin
          send_pct = 13;
          stall_pct = 13;
        end
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (p == 2 && i == ITEMS_PER_PHASE / 2) begin
          @(negedge clk);
          in_valid = 1'b0;
          while (pending_results.size() != 0) begin
            @(posedge clk);
          end
        end
        send_request(random_request(), 1'b0, '0);
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d console requests and checked %0d result words across %0d register",
             n_requests, n_results, PHASES);
    $display("settings, with pacing from back-to-back to heavy gaps and stalls on both sides.");
    if (n_errors == 0) begin
      $display("text_console_writer_core_tb OK");
    end else begin
      $display("text_console_writer_core_tb NOT OK");
    end
    $finish;
  end

endmodule
